>>> hw/rtl/aegis128_authenticated_cipher_macros.svh
// Assertion helpers for the AEGIS-128 engine
`ifndef AEGIS128_AUTHENTICATED_CIPHER_MACROS_SVH
`define AEGIS128_AUTHENTICATED_CIPHER_MACROS_SVH

// implication checked on every rising clock edge, off while in reset
`define AEG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the following cycle
`define AEG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/aeg128_pkg.sv
// ----------------------------------------------------------------------------
// aeg128_pkg
// Shared types, constants and AES round function for the AEGIS-128 engine.
// ----------------------------------------------------------------------------
package aeg128_pkg;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_AD     = 2'd1;
  localparam logic [1:0] CMD_MSG    = 2'd2;
  localparam logic [1:0] CMD_FINISH = 2'd3;

  localparam logic [2:0] REG_KEY_LO   = 3'd0;
  localparam logic [2:0] REG_KEY_HI   = 3'd1;
  localparam logic [2:0] REG_NONCE_LO = 3'd2;
  localparam logic [2:0] REG_NONCE_HI = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;

  localparam logic [3:0] INIT_ROUNDS = 4'd10;
  localparam logic [3:0] FIN_ROUNDS  = 4'd7;

  localparam logic [127:0] CONST0 = 128'h6279e99059372215_0d08050302010100;
  localparam logic [127:0] CONST1 = 128'hdd28b57342311120_f12fc26d55183ddb;

  // datapath operation
  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_INIT_UPD, OP_AD_UPD, OP_MSG_UPD, OP_FIN_PREP, OP_FIN_UPD, OP_TAG
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       count;   // bump byte counters
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // one AES round without key add; byte i sits at bits [8i+7:8i]
  function automatic logic [127:0] aes_round(input logic [127:0] din);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[k + 4*c] = SBOX[din[8*(k + 4*((c + k) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      r[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      r[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      r[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      r[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    aes_round = r;
  endfunction

endpackage

>>> hw/rtl/aeg128_datapath.sv
// ----------------------------------------------------------------------------
// aeg128_datapath
// Five-word state, state update unit, byte counters and result register.
// ----------------------------------------------------------------------------
module aeg128_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  aeg128_pkg::dp_cmd_t   cmd_i,
  input  logic [127:0]          key_i,
  input  logic [127:0]          nonce_i,
  input  logic                  decrypt_i,
  input  logic [127:0]          data_i,
  input  logic [4:0]            nbytes_i,
  output logic [127:0]          res_data_o,
  output logic                  res_match_o
);

  logic [127:0] s_q [5];
  logic [127:0] s_d [5];
  logic [127:0] m_q, m_d;
  logic [63:0]  ad_cnt_q, ad_cnt_d, msg_cnt_q, msg_cnt_d;
  logic [127:0] res_q, res_d;
  logic         match_q, match_d;
  logic [127:0] rtag_q, rtag_d;
  logic [127:0] mask, dmask, ks, otxt, msg_in, tag, upd [5];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask[8*i +: 8] = (5'(i) < nbytes_i) ? 8'hff : 8'h00;
    end
    dmask = data_i & mask;
    ks    = s_q[1] ^ s_q[4] ^ (s_q[2] & s_q[3]);
    otxt  = (dmask ^ ks) & mask;
    tag   = s_q[0] ^ s_q[1] ^ s_q[2] ^ s_q[3] ^ s_q[4];
    case (cmd_i.op)
      aeg128_pkg::OP_INIT_UPD, aeg128_pkg::OP_FIN_UPD: msg_in = m_q;
      aeg128_pkg::OP_MSG_UPD: msg_in = decrypt_i ? otxt : dmask;
      default:                msg_in = dmask;
    endcase
    upd[0] = aeg128_pkg::aes_round(s_q[4]) ^ s_q[0] ^ msg_in;
    for (int i = 1; i < 5; i++) begin
      upd[i] = aeg128_pkg::aes_round(s_q[i-1]) ^ s_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) s_d[i] = s_q[i];
    m_d       = m_q;
    ad_cnt_d  = ad_cnt_q;
    msg_cnt_d = msg_cnt_q;
    res_d     = res_q;
    match_d   = match_q;
    rtag_d    = rtag_q;
    case (cmd_i.op)
      aeg128_pkg::OP_LOAD: begin
        s_d[0] = key_i ^ nonce_i;
        s_d[1] = aeg128_pkg::CONST1;
        s_d[2] = aeg128_pkg::CONST0;
        s_d[3] = key_i ^ aeg128_pkg::CONST0;
        s_d[4] = key_i ^ aeg128_pkg::CONST1;
        m_d    = key_i;
        ad_cnt_d  = '0;
        msg_cnt_d = '0;
      end
      aeg128_pkg::OP_INIT_UPD: begin
        for (int i = 0; i < 5; i++) s_d[i] = upd[i];
        m_d = m_q ^ nonce_i;
      end
      aeg128_pkg::OP_AD_UPD: begin
        for (int i = 0; i < 5; i++) s_d[i] = upd[i];
        if (cmd_i.count) ad_cnt_d = ad_cnt_q + 64'(nbytes_i);
      end
      aeg128_pkg::OP_MSG_UPD: begin
        for (int i = 0; i < 5; i++) s_d[i] = upd[i];
        if (cmd_i.count) msg_cnt_d = msg_cnt_q + 64'(nbytes_i);
        res_d   = otxt;
        match_d = 1'b0;
      end
      aeg128_pkg::OP_FIN_PREP: begin
        m_d    = {msg_cnt_q[60:0], 3'b000, ad_cnt_q[60:0], 3'b000} ^ s_q[3];
        // received tag is held until the compare at the end of finish
        rtag_d = data_i;
      end
      aeg128_pkg::OP_FIN_UPD: begin
        for (int i = 0; i < 5; i++) s_d[i] = upd[i];
      end
      aeg128_pkg::OP_TAG: begin
        res_d   = tag;
        match_d = decrypt_i && (tag == rtag_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) s_q[i] <= '0;
      ad_cnt_q  <= '0;
      msg_cnt_q <= '0;
    end else begin
      for (int i = 0; i < 5; i++) s_q[i] <= s_d[i];
      ad_cnt_q  <= ad_cnt_d;
      msg_cnt_q <= msg_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    res_q   <= res_d;
    match_q <= match_d;
    rtag_q  <= rtag_d;
  end

  assign res_data_o  = res_q;
  assign res_match_o = match_q;

endmodule

>>> hw/rtl/aeg128_ctrl.sv
// ----------------------------------------------------------------------------
// aeg128_ctrl
// Sequencer: accepts items, issues update steps, holds the result handshake.
// ----------------------------------------------------------------------------
module aeg128_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  logic [4:0]           nbytes_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [4:0]           out_nbytes_o,
  output logic                 out_kind_o,
  output aeg128_pkg::dp_cmd_t  dp_cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_FPRE = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_TAG  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       ovalid_q, ovalid_d;
  logic [4:0] onb_q, onb_d;
  logic       okind_q, okind_d;
  logic       acc;
  logic [4:0] nb;

  // capped byte count
  assign nb = (nbytes_i > 5'd16) ? 5'd16 : nbytes_i;
  // finish needs the output register free before the tag lands
  assign in_ready_o = (state_q == ST_IDLE) && (!ovalid_q || out_ready_i);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !out_ready_i;
    onb_d    = onb_q;
    okind_d  = okind_q;
    dp_cmd_o = '{op: aeg128_pkg::OP_NONE, count: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (cmd_i)
            aeg128_pkg::CMD_START: begin
              dp_cmd_o.op = aeg128_pkg::OP_LOAD;
              cnt_d   = aeg128_pkg::INIT_ROUNDS;
              state_d = ST_INIT;
            end
            aeg128_pkg::CMD_AD: begin
              if (nb != 5'd0) dp_cmd_o = '{op: aeg128_pkg::OP_AD_UPD, count: 1'b1};
            end
            aeg128_pkg::CMD_MSG: begin
              if (nb != 5'd0) begin
                dp_cmd_o = '{op: aeg128_pkg::OP_MSG_UPD, count: 1'b1};
                ovalid_d = 1'b1;
                onb_d    = nb;
                okind_d  = 1'b0;
              end
            end
            aeg128_pkg::CMD_FINISH: begin
              dp_cmd_o.op = aeg128_pkg::OP_FIN_PREP;
              cnt_d   = aeg128_pkg::FIN_ROUNDS;
              state_d = ST_FIN;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        dp_cmd_o.op = aeg128_pkg::OP_INIT_UPD;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) state_d = ST_IDLE;
      end
      ST_FIN: begin
        dp_cmd_o.op = aeg128_pkg::OP_FIN_UPD;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) state_d = ST_TAG;
      end
      ST_TAG: begin
        dp_cmd_o.op = aeg128_pkg::OP_TAG;
        ovalid_d = 1'b1;
        onb_d    = 5'd16;
        okind_d  = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    onb_q   <= onb_d;
    okind_q <= okind_d;
  end

  assign out_valid_o  = ovalid_q;
  assign out_nbytes_o = onb_q;
  assign out_kind_o   = okind_q;

endmodule

>>> hw/rtl/aegis128_authenticated_cipher.sv
// ----------------------------------------------------------------------------
// aegis128_authenticated_cipher
// AEGIS-128 authenticated encryption / decryption engine.
// ----------------------------------------------------------------------------
// Input stream s_axis: tdata = {valid_bytes, data_high, data_low}, tuser = cmd
// (start, AD block, message block, finish). Output stream m_axis: tdata =
// {out_valid_bytes, out_high, out_low}, tuser = {tag_match, result_kind}.
// Key, nonce and mode are written via cfg_we_i / cfg_idx_i / cfg_wdata_i; the
// user must write them only while idle, which the block does not enforce.
// Sequencing: AD and message blocks take one state update each; a message
// block's result is registered on accept, and a new item can be taken in the
// next cycle if no output is held or it is being taken. Start is a load plus
// ten updates; finish is length setup, seven updates and the tag, and returns
// the tag. All updates share one five-lane AES round unit.
// Reset clears the state, byte counters, sequencer and config registers, not
// the result register. A stalled receiver holds the output register; a new item
// is accepted only once it is free or being taken in the same cycle.
// ----------------------------------------------------------------------------
`include "aegis128_authenticated_cipher_macros.svh"

module aegis128_authenticated_cipher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [135:0]  s_axis_tdata,   // data_low, data_high, valid_bytes, pad
  input  logic [1:0]    s_axis_tuser,   // cmd
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [135:0]  m_axis_tdata,   // out_low, out_high, out_valid_bytes, pad
  output logic [1:0]    m_axis_tuser,   // result_kind, tag_match
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_wdata_i
);

  logic [63:0] key_lo_q, key_hi_q, nonce_lo_q, nonce_hi_q;
  logic        mode_q;
  aeg128_pkg::dp_cmd_t dp_cmd;
  logic [127:0] res_data;
  logic         res_match;
  logic [4:0]   onb;
  logic         okind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0; key_hi_q <= '0; nonce_lo_q <= '0; nonce_hi_q <= '0;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aeg128_pkg::REG_KEY_LO:   key_lo_q   <= cfg_wdata_i;
        aeg128_pkg::REG_KEY_HI:   key_hi_q   <= cfg_wdata_i;
        aeg128_pkg::REG_NONCE_LO: nonce_lo_q <= cfg_wdata_i;
        aeg128_pkg::REG_NONCE_HI: nonce_hi_q <= cfg_wdata_i;
        aeg128_pkg::REG_MODE:     mode_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  aeg128_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .nbytes_i     (s_axis_tdata[132:128]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_nbytes_o (onb),
    .out_kind_o   (okind),
    .dp_cmd_o     (dp_cmd)
  );

  aeg128_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i       (dp_cmd),
    .key_i       ({key_hi_q, key_lo_q}),
    .nonce_i     ({nonce_hi_q, nonce_lo_q}),
    .decrypt_i   (mode_q),
    .data_i      (s_axis_tdata[127:0]),
    .nbytes_i    ((s_axis_tdata[132:128] > 5'd16) ? 5'd16 : s_axis_tdata[132:128]),
    .res_data_o  (res_data),
    .res_match_o (res_match)
  );

  assign m_axis_tdata = {3'b000, onb, res_data};
  assign m_axis_tuser = {res_match, okind};

  `AEG_ASSERT_IMP(a_busy_not_ready, s_axis_tready, !(m_axis_tvalid && !m_axis_tready))
  `AEG_ASSERT_NEXT(a_msg_gives_result,
    s_axis_tvalid && s_axis_tready && s_axis_tuser == aeg128_pkg::CMD_MSG &&
    s_axis_tdata[132:128] != 5'd0, m_axis_tvalid && !m_axis_tuser[0])
  `AEG_ASSERT_IMP(a_tag_full, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[132:128] == 5'd16)
  `AEG_ASSERT_IMP(a_match_tag_only, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])

endmodule
